// ===== sv/lis_pkg.sv =====
// Package: shared types, register indexes, status codes and constants of the ignition sequencer
package lis_pkg;

    // Fixed field widths
    localparam int unsigned TICK_W   = 16;
    localparam int unsigned ATT_W    = 8;
    localparam int unsigned SUM_W    = 32;
    localparam int unsigned SAMPLE_W = 16;
    localparam int unsigned THR_W    = 17;
    localparam int unsigned CFG_W    = 16;
    localparam int unsigned IDX_W    = 3;

    // Threshold scaling: ((work_current * CURR_SCALE) >> CURR_FRAC) - CURR_OFFSET
    localparam int unsigned SCALE_W     = 14;
    localparam int unsigned CURR_FRAC   = 15;
    localparam int unsigned PROD_W      = CFG_W + SCALE_W;
    localparam logic [SCALE_W-1:0] CURR_SCALE  = SCALE_W'(15305);
    localparam logic [THR_W-1:0]   CURR_OFFSET = THR_W'(713);

    // Default averaging shift
    localparam int unsigned AVERAGE_SHIFT_DEF = 13;

    // Register reset values
    localparam logic [TICK_W-1:0] PULSE_RST = TICK_W'(100);
    localparam logic [TICK_W-1:0] PAUSE_RST = TICK_W'(100);
    localparam logic [TICK_W-1:0] POLL_RST  = TICK_W'(8192);
    localparam logic [ATT_W-1:0]  MAXATT_RST = ATT_W'(10);
    // threshold for a work current of zero
    localparam logic [THR_W-1:0]  THR_RST   = THR_W'(0) - CURR_OFFSET;

    // Register indexes
    typedef enum logic [IDX_W-1:0] {
        REG_PULSE   = 3'd0,
        REG_PAUSE   = 3'd1,
        REG_POLL    = 3'd2,
        REG_MAXATT  = 3'd3,
        REG_WORKCUR = 3'd4
    } t_reg_idx;

    // Result status codes
    typedef enum logic [1:0] {
        ST_WAIT = 2'd0,
        ST_OK   = 2'd1,
        ST_FAIL = 2'd2
    } t_status;

    // Configuration as seen by the sequencer core
    typedef struct packed {
        logic [TICK_W-1:0]       pulse_ticks;
        logic [TICK_W-1:0]       pause_ticks;
        logic [TICK_W-1:0]       polling_ticks;
        logic [ATT_W-1:0]        max_attempts;
        logic signed [THR_W-1:0] threshold;
    } t_cfg;

endpackage

// ===== sv/lis_in_if.sv =====
// Interface: input tick channel (start request and current sample)
interface lis_in_if;
    logic               valid;
    logic               ready;
    logic               start_request;
    logic signed [15:0] current_sample;

    modport source (output valid, start_request, current_sample, input ready);
    modport sink   (input valid, start_request, current_sample, output ready);
endinterface

// ===== sv/lis_out_if.sv =====
// Interface: result channel (status and drive outputs)
interface lis_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] status;
    logic       lightup_drive;
    logic       backlight_drive;
    logic       current_loop_enable;

    modport source (output valid, status, lightup_drive, backlight_drive,
                    current_loop_enable, input ready);
    modport sink   (input valid, status, lightup_drive, backlight_drive,
                    current_loop_enable, output ready);
endinterface

// ===== sv/lis_cfg.sv =====
// Configuration register file, with the polling threshold worked out at write time
module lis_cfg (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [lis_pkg::IDX_W-1:0] i_cfg_idx,
    input  logic [lis_pkg::CFG_W-1:0] i_cfg_data,
    output lis_pkg::t_cfg             o_cfg
);
    import lis_pkg::*;

    t_cfg                r_cfg;
    logic [PROD_W-1:0]   prod;
    logic [THR_W-1:0]    thr_new;

    // threshold = (work_current * scale >> frac) - offset
    assign prod    = PROD_W'(i_cfg_data) * PROD_W'(CURR_SCALE);
    assign thr_new = THR_W'(prod[PROD_W-1:CURR_FRAC]) - CURR_OFFSET;

    // Register writes; unknown indexes are ignored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.pulse_ticks   <= PULSE_RST;
            r_cfg.pause_ticks   <= PAUSE_RST;
            r_cfg.polling_ticks <= POLL_RST;
            r_cfg.max_attempts  <= MAXATT_RST;
            r_cfg.threshold     <= THR_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_PULSE:   r_cfg.pulse_ticks   <= i_cfg_data;
                REG_PAUSE:   r_cfg.pause_ticks   <= i_cfg_data;
                REG_POLL:    r_cfg.polling_ticks <= i_cfg_data;
                REG_MAXATT:  r_cfg.max_attempts  <= i_cfg_data[ATT_W-1:0];
                REG_WORKCUR: r_cfg.threshold     <= thr_new;
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== sv/lis_core.sv =====
// Sequencer core: tick state, phase machine and registered result
module lis_core #(
    parameter int unsigned AVERAGE_SHIFT = lis_pkg::AVERAGE_SHIFT_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  lis_pkg::t_cfg i_cfg,
    lis_in_if.sink        i_item,
    lis_out_if.source     o_result
);
    import lis_pkg::*;

    typedef enum logic [1:0] {
        PH_FREE  = 2'd0,
        PH_PULSE = 2'd1,
        PH_PAUSE = 2'd2,
        PH_POLL  = 2'd3
    } t_phase;

    // State
    t_phase             r_phase,   n_phase;
    logic [TICK_W-1:0]  r_cnt,     n_cnt;
    logic [SUM_W-1:0]   r_sum,     n_sum;
    logic [ATT_W-1:0]   r_att,     n_att;
    logic               r_pend,    n_pend;
    logic               r_started, n_started;
    logic               r_busy,    n_busy;
    logic               r_first,   n_first;
    logic               r_lu,      n_lu;
    logic               r_bl,      n_bl;
    logic               r_le,      n_le;
    // Result register
    logic               r_valid;
    t_status            r_status,  n_status;

    logic               accept;
    logic [TICK_W-1:0]  len;
    logic [TICK_W-1:0]  cnt_v;
    logic               cont;
    logic               finish;
    t_status            att_res;
    logic signed [SUM_W-1:0] avg;
    logic signed [SUM_W-1:0] thr_ext;
    logic [SUM_W-1:0]   sample_ext;

    // Skid via output register: take a new item whenever the result slot frees
    assign i_item.ready = !r_valid || o_result.ready;
    assign accept       = i_item.valid && i_item.ready;

    assign sample_ext = SUM_W'(i_item.current_sample) |
                        ({SUM_W{i_item.current_sample[SAMPLE_W-1]}} << SAMPLE_W);
    assign avg        = $signed(r_sum) >>> AVERAGE_SHIFT;
    assign thr_ext    = SUM_W'(i_cfg.threshold) |
                        ({SUM_W{i_cfg.threshold[THR_W-1]}} << THR_W);

    // Next state for one tick
    always_comb begin
        n_phase   = r_phase;
        n_cnt     = r_cnt;
        n_sum     = r_sum;
        n_att     = r_att;
        n_pend    = r_pend || i_item.start_request;
        n_started = r_started;
        n_busy    = r_busy;
        n_first   = r_first;
        n_lu      = r_lu;
        n_bl      = r_bl;
        n_le      = r_le;
        n_status  = ST_WAIT;
        att_res   = ST_WAIT;
        finish    = 1'b0;
        len       = i_cfg.polling_ticks;
        cnt_v     = r_cnt;
        cont      = 1'b0;

        if (n_pend) begin
            // sequence start
            if (!r_started) begin
                n_bl      = 1'b1;
                n_started = 1'b1;
                n_att     = '0;
                n_busy    = 1'b0;
            end
            if (n_phase == PH_FREE) begin
                n_phase = PH_PULSE;
            end

            // phase length and entry actions
            case (n_phase)
                PH_PULSE: begin
                    len = i_cfg.pulse_ticks;
                    if (!n_busy) n_lu = 1'b1;
                end
                PH_PAUSE: len = i_cfg.pause_ticks;
                default: begin
                    len = i_cfg.polling_ticks;
                    if (!n_busy) n_sum = '0;
                end
            endcase

            // tick counter: load on entry, count down; zero length acts as one
            cnt_v = n_busy ? r_cnt : len;
            if (cnt_v != '0) cnt_v = cnt_v - TICK_W'(1);
            cont   = (cnt_v != '0);
            n_cnt  = cnt_v;
            n_busy = cont;

            // phase end
            case (n_phase)
                PH_PULSE: begin
                    if (!cont) begin
                        n_lu    = 1'b0;
                        n_phase = PH_PAUSE;
                    end
                end
                PH_PAUSE: begin
                    if (!cont) n_phase = PH_POLL;
                end
                default: begin
                    if (cont) begin
                        n_sum = n_sum + sample_ext;
                    end else begin
                        n_sum   = '0;
                        n_phase = PH_FREE;
                        att_res = (avg > thr_ext) ? ST_OK : ST_FAIL;
                    end
                end
            endcase

            // attempt outcome
            if (att_res == ST_OK) begin
                n_status = ST_OK;
                finish   = 1'b1;
            end else if (att_res == ST_FAIL) begin
                if (r_first) begin
                    n_att = n_att + ATT_W'(1);
                    if (n_att >= i_cfg.max_attempts) begin
                        n_status = ST_FAIL;
                        finish   = 1'b1;
                    end
                end else begin
                    n_status = ST_FAIL;
                    finish   = 1'b1;
                end
            end

            // sequence end; the first one also enables the current loop
            if (finish) begin
                n_pend    = 1'b0;
                n_started = 1'b0;
                n_busy    = 1'b0;
                if (r_first) n_le = 1'b1;
                n_first   = 1'b0;
                n_bl      = 1'b0;
            end
        end
    end

    // State and result registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_FREE;
            r_cnt     <= '0;
            r_sum     <= '0;
            r_att     <= '0;
            r_pend    <= 1'b1;
            r_started <= 1'b0;
            r_busy    <= 1'b0;
            r_first   <= 1'b1;
            r_lu      <= 1'b0;
            r_bl      <= 1'b0;
            r_le      <= 1'b0;
            r_valid   <= 1'b0;
            r_status  <= ST_WAIT;
        end else begin
            if (accept) begin
                r_phase   <= n_phase;
                r_cnt     <= n_cnt;
                r_sum     <= n_sum;
                r_att     <= n_att;
                r_pend    <= n_pend;
                r_started <= n_started;
                r_busy    <= n_busy;
                r_first   <= n_first;
                r_lu      <= n_lu;
                r_bl      <= n_bl;
                r_le      <= n_le;
                r_status  <= n_status;
                r_valid   <= 1'b1;
            end else if (o_result.ready) begin
                r_valid   <= 1'b0;
            end
        end
    end

    assign o_result.valid               = r_valid;
    assign o_result.status              = r_status;
    assign o_result.lightup_drive       = r_lu;
    assign o_result.backlight_drive     = r_bl;
    assign o_result.current_loop_enable = r_le;

endmodule

// ===== sv/laser_ignition_sequencer.sv =====
// Top level: laser ignition sequencer with configuration port and item channels
//
// Each input item is one tick carrying a start request and a signed current sample; each
// accepted item yields exactly one result item (status, light-up drive, backlight drive,
// current-loop enable) in the next cycle. One item is accepted every clock cycle unless the
// output stalls: the tick's whole update runs in a single pass from the state registers to
// the result register, and the result register frees for the next item as soon as the sink
// takes the previous one, so throughput is limited only by the output's ready. The polling
// threshold is computed from work_current when that register is written, so configuration
// takes effect on the very next item. After reset a start request is already pending.
module laser_ignition_sequencer #(
    parameter int unsigned AVERAGE_SHIFT = lis_pkg::AVERAGE_SHIFT_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [lis_pkg::IDX_W-1:0] i_cfg_idx,
    input  logic [lis_pkg::CFG_W-1:0] i_cfg_data,
    lis_in_if.sink                    i_item,
    lis_out_if.source                 o_result
);
    import lis_pkg::*;

    t_cfg cfg;

    // Configuration registers
    lis_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    // Sequencer
    lis_core #(
        .AVERAGE_SHIFT (AVERAGE_SHIFT)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (cfg),
        .i_item   (i_item),
        .o_result (o_result)
    );

    // Light-up pulse only ever runs inside a started sequence
    a_lightup_in_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.valid && o_result.lightup_drive |-> o_result.backlight_drive)
        else $error("light-up drive without backlight");

    // A final status ends the sequence, so the backlight is off with it
    a_final_ends_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.valid && (o_result.status != ST_WAIT) |->
            !o_result.backlight_drive && !o_result.lightup_drive)
        else $error("final status while sequence still running");

    // Status is never the unused code
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.valid |->
            (o_result.status == ST_WAIT) || (o_result.status == ST_OK) ||
            (o_result.status == ST_FAIL))
        else $error("bad status code");

    // Current loop, once enabled, stays enabled
    a_loop_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && $past(o_result.valid) && $past(o_result.current_loop_enable) |->
            !o_result.valid || o_result.current_loop_enable)
        else $error("current loop enable dropped");

endmodule
